>>> rtl/cggs_pkg.sv
`default_nettype none

package cggs_pkg;

    // Field widths fixed by the register and item layout.
    localparam int WIN_W      = 5;
    localparam int THR_W      = 16;
    localparam int SEEN_W     = 6;
    localparam int HALF_W     = 4;
    localparam int DIST_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;
    localparam logic [WIN_W-1:0]  MIN_SMOOTH_WINDOW = 5'd3;
    localparam logic [WIN_W-1:0]  WINDOW_RESET = 5'd1;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE      = 1'b0,
        CFG_CORNER_THRESHOLD = 1'b1
    } cfg_index_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic              take_point;
        logic              diff_en;
        logic              square_en;
        logic              flag_wr;
        logic              sweep_start;
        logic [DIST_W-1:0] center;
        logic [HALF_W-1:0] half;
        logic              smooth;
        logic              out_load;
        logic              out_last;
    } cggs_cmd_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic sweep_idle;
        logic out_free;
    } cggs_status_t;

endpackage

`default_nettype wire

>>> rtl/cggs_if.sv
`default_nettype none

interface cggs_point_if #(parameter int COORD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

interface cggs_result_if #(parameter int COORD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic                  out_last;

    modport source (output valid, output out_x, output out_y, output out_last,
                    input ready);
    modport sink   (input valid, input out_x, input out_y, input out_last,
                    output ready);
endinterface

interface cggs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cggs_pkg::CFG_IDX_W-1:0]   index;
    logic [cggs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/cggs_datapath.sv
`default_nettype none

module cggs_datapath #(
    parameter int MAX_WINDOW  = 31,
    parameter int COORD_BITS  = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cggs_pkg::cggs_cmd_t           cmd,
    output cggs_pkg::cggs_status_t        status,
    input  logic [COORD_BITS-1:0]         in_x,
    input  logic [COORD_BITS-1:0]         in_y,
    input  logic [cggs_pkg::THR_W-1:0]    corner_threshold,
    output logic [COORD_BITS-1:0]         out_x,
    output logic [COORD_BITS-1:0]         out_y,
    output logic                          out_last,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
    localparam int HALF_AW  = $clog2(HALF_MAX + 1);
    localparam int RING_AW  = $clog2(MAX_WINDOW + 1);
    localparam int RING_D   = 1 << RING_AW;
    localparam int PT_W     = 2 * COORD_BITS;
    localparam int DIFF_W   = COORD_BITS + 3;
    localparam int MAG_W    = COORD_BITS + 2;
    localparam int MAGX_W   = (MAG_W > cggs_pkg::THR_W + 1) ? MAG_W : cggs_pkg::THR_W + 1;
    localparam int SQ_W     = 2 * cggs_pkg::THR_W;
    localparam int PROD_W   = COORD_BITS + WEIGHT_BITS;
    localparam int ACC_W    = PROD_W + 1;
    localparam int DW       = cggs_pkg::DIST_W;

    typedef logic [HALF_MAX:0][HALF_MAX:0][WEIGHT_BITS-1:0] rom_t;

    // Unsigned quotient by shift and subtract; only evaluated while the weight
    // table is built.
    function automatic logic [63:0] quotient(input logic [63:0] num,
                                             input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a) with a in Q30, Taylor series truncated after the a^24 term.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = 64'd1 << 30;
        sum  = $signed(64'd1 << 30);
        for (int n = 1; n <= 24; n++)
        begin
            term = quotient((term * a) >> 30, 64'(n));
            if (n[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        return (sum > 0) ? 64'(sum) : 64'd0;
    endfunction

    // Normalized Gaussian weights per half-width, sigma = h/2; each row sums to 2^WEIGHT_BITS.
    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] g;
        logic [63:0] s;
        logic [63:0] w;
        logic [63:0] sides;
        logic [63:0] hh;
        rom = '0;
        for (int h = 1; h <= HALF_MAX; h++)
        begin
            hh = 64'(h * h);
            s  = 64'd0;
            for (int t = 0; t <= h; t++)
            begin
                g = exp_neg_q30(quotient(64'(2 * t * t) << 30, hh));
                s = s + ((t == 0) ? g : 64'd2 * g);
            end
            sides = 64'd0;
            for (int t = 1; t <= h; t++)
            begin
                g = exp_neg_q30(quotient(64'(2 * t * t) << 30, hh));
                w = quotient((g << WEIGHT_BITS) + (s >> 1), s);
                rom[h][t] = WEIGHT_BITS'(w);
                sides = sides + 64'd2 * w;
            end
            rom[h][0] = WEIGHT_BITS'((64'd1 << WEIGHT_BITS) - sides);
        end
        return rom;
    endfunction

    localparam rom_t WEIGHT_ROM = build_rom();

    function automatic logic [MAG_W-1:0] mag2(input logic [COORD_BITS-1:0] a,
                                              input logic [COORD_BITS-1:0] b,
                                              input logic [COORD_BITS-1:0] c);
        logic signed [DIFF_W-1:0] v;
        v = $signed({3'b000, a}) - $signed({2'b00, b, 1'b0}) + $signed({3'b000, c});
        return v[DIFF_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // Ring of recent points.
    logic [PT_W-1:0]    ring_mem [RING_D];
    logic [PT_W-1:0]    rd_data_reg;
    logic [RING_AW-1:0] head_reg;
    logic [RING_AW-1:0] cur_reg;
    logic [RING_AW-1:0] rd_addr;
    logic [RING_D-1:0]  flags_reg;

    // Last three points for the second difference.
    logic [COORD_BITS-1:0] x0_reg, x1_reg, x2_reg;
    logic [COORD_BITS-1:0] y0_reg, y1_reg, y2_reg;

    logic [MAG_W-1:0]           mag_x, mag_y;
    logic [MAGX_W-1:0]          magx_ext, magy_ext;
    logic                       ovf_reg;
    logic [cggs_pkg::THR_W-1:0] magx_reg, magy_reg;
    logic [SQ_W-1:0]            sqx_reg, sqy_reg, thr2_reg;
    logic                       flag_val;

    // Sweep over the window taps.
    logic                  sw_active_reg;
    logic [DW-1:0]         e_reg, left_reg, d_reg;
    logic [cggs_pkg::HALF_W-1:0] h_reg;
    logic                  smooth_reg;
    logic [DW-1:0]         tap_dist;
    logic                  s1_valid_reg, s1_flag_reg, s1_center_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic                  s2_valid_reg;
    logic [PROD_W-1:0]     prod_x_reg, prod_y_reg;
    logic [ACC_W-1:0]      acc_x_reg, acc_y_reg;
    logic                  near_reg;
    logic [PT_W-1:0]       center_pt_reg;
    logic [ACC_W-1:0]      round_x, round_y;
    logic [COORD_BITS-1:0] res_x, res_y;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                  out_last_reg;

    assign mag_x    = mag2(x2_reg, x1_reg, x0_reg);
    assign mag_y    = mag2(y2_reg, y1_reg, y0_reg);
    assign magx_ext = MAGX_W'(mag_x);
    assign magy_ext = MAGX_W'(mag_y);
    assign flag_val = ovf_reg ||
                      (({1'b0, sqx_reg} + {1'b0, sqy_reg}) > {1'b0, thr2_reg});

    assign rd_addr  = cur_reg - RING_AW'(e_reg);
    assign tap_dist = (e_reg > d_reg) ? (e_reg - d_reg) : (d_reg - e_reg);

    assign round_x  = acc_x_reg + ACC_W'(1 << (WEIGHT_BITS - 1));
    assign round_y  = acc_y_reg + ACC_W'(1 << (WEIGHT_BITS - 1));
    assign res_x    = (smooth_reg && near_reg) ? round_x[WEIGHT_BITS +: COORD_BITS]
                                               : center_pt_reg[PT_W-1:COORD_BITS];
    assign res_y    = (smooth_reg && near_reg) ? round_y[WEIGHT_BITS +: COORD_BITS]
                                               : center_pt_reg[COORD_BITS-1:0];

    assign status.sweep_idle = !sw_active_reg && !s1_valid_reg && !s2_valid_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_point)
        begin
            ring_mem[head_reg] <= {in_x, in_y};
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cur_reg       <= '0;
            flags_reg     <= '0;
            sw_active_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_point)
            begin
                cur_reg             <= head_reg;
                head_reg            <= head_reg + RING_AW'(1);
                flags_reg[head_reg] <= 1'b0;
            end
            if (cmd.flag_wr)
            begin
                flags_reg[cur_reg - RING_AW'(1)] <= flag_val;
            end
            if (cmd.sweep_start)
            begin
                sw_active_reg <= 1'b1;
            end
            else if (sw_active_reg && left_reg == DW'(1))
            begin
                sw_active_reg <= 1'b0;
            end
            s1_valid_reg <= sw_active_reg;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_point)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x0_reg;
            x0_reg <= in_x;
            y2_reg <= y1_reg;
            y1_reg <= y0_reg;
            y0_reg <= in_y;
        end
        if (cmd.diff_en)
        begin
            ovf_reg  <= (|magx_ext[MAGX_W-1:cggs_pkg::THR_W]) ||
                        (|magy_ext[MAGX_W-1:cggs_pkg::THR_W]);
            magx_reg <= magx_ext[cggs_pkg::THR_W-1:0];
            magy_reg <= magy_ext[cggs_pkg::THR_W-1:0];
        end
        if (cmd.square_en)
        begin
            sqx_reg  <= SQ_W'(magx_reg) * SQ_W'(magx_reg);
            sqy_reg  <= SQ_W'(magy_reg) * SQ_W'(magy_reg);
            thr2_reg <= SQ_W'(corner_threshold) * SQ_W'(corner_threshold);
        end

        // Tap issue: address, flag and weight for one tap per cycle.
        if (cmd.sweep_start)
        begin
            d_reg      <= cmd.center;
            h_reg      <= cmd.half;
            smooth_reg <= cmd.smooth;
            e_reg      <= cmd.smooth ? (cmd.center - DW'(cmd.half)) : cmd.center;
            left_reg   <= cmd.smooth ? DW'({cmd.half, 1'b1}) : DW'(1);
            near_reg   <= 1'b0;
            acc_x_reg  <= '0;
            acc_y_reg  <= '0;
        end
        else
        begin
            if (sw_active_reg)
            begin
                e_reg    <= e_reg + DW'(1);
                left_reg <= left_reg - DW'(1);
            end
            if (s1_valid_reg)
            begin
                near_reg <= near_reg | s1_flag_reg;
            end
            if (s2_valid_reg)
            begin
                acc_x_reg <= acc_x_reg + ACC_W'(prod_x_reg);
                acc_y_reg <= acc_y_reg + ACC_W'(prod_y_reg);
            end
        end
        s1_flag_reg   <= flags_reg[rd_addr];
        s1_center_reg <= (e_reg == d_reg);
        w_reg         <= WEIGHT_ROM[HALF_AW'(h_reg)][HALF_AW'(tap_dist)];

        // Multiply stage.
        if (s1_valid_reg)
        begin
            prod_x_reg <= PROD_W'(rd_data_reg[PT_W-1:COORD_BITS]) * PROD_W'(w_reg);
            prod_y_reg <= PROD_W'(rd_data_reg[COORD_BITS-1:0]) * PROD_W'(w_reg);
            if (s1_center_reg)
            begin
                center_pt_reg <= rd_data_reg;
            end
        end

        if (cmd.out_load)
        begin
            out_x_reg    <= res_x;
            out_y_reg    <= res_y;
            out_last_reg <= cmd.out_last;
        end
    end

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_start |-> (!sw_active_reg && !s1_valid_reg && !s2_valid_reg))
        else $error("sweep started while a sweep is in flight");

    a_point_not_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_point |-> (!sw_active_reg && !s1_valid_reg && !s2_valid_reg))
        else $error("point written into the ring during a sweep");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending output");

    a_sweep_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_start |=> (sw_active_reg && !status.sweep_idle))
        else $error("sweep did not begin after start");

endmodule

`default_nettype wire

>>> rtl/cggs_ctrl.sv
`default_nettype none

module cggs_ctrl #(
    parameter int MAX_WINDOW = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_last,
    output logic                          in_ready,
    input  logic [cggs_pkg::WIN_W-1:0]    window_size,
    output cggs_pkg::cggs_cmd_t           cmd,
    input  cggs_pkg::cggs_status_t        status
);

    localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
    localparam int SW = cggs_pkg::SEEN_W;
    localparam int DW = cggs_pkg::DIST_W;
    localparam int HW = cggs_pkg::HALF_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQUARE,
        S_FLAG,
        S_START,
        S_RUN,
        S_OUT
    } state_t;

    state_t          state_reg;
    logic [SW-1:0]   k_reg;
    logic [HW-1:0]   half_reg;
    logic [DW-1:0]   d_reg;
    logic            last_reg;

    logic [HW-1:0]   half_raw;
    logic [HW-1:0]   half_new;
    logic [SW-1:0]   k_inc;
    logic [SW-1:0]   h_plus1;
    logic            eligible;
    logic            accept;

    assign half_raw = (window_size < cggs_pkg::MIN_SMOOTH_WINDOW) ? '0
                                                                  : window_size[HW:1];
    assign half_new = (int'(half_raw) > HALF_MAX) ? HW'(HALF_MAX) : half_raw;
    assign k_inc    = (k_reg == cggs_pkg::SEEN_MAX) ? k_reg : k_reg + SW'(1);
    assign h_plus1  = SW'(half_reg) + SW'(1);
    assign eligible = (half_reg != '0) && (SW'(d_reg) >= SW'(half_reg)) &&
                      (k_reg >= SW'(half_reg) + SW'(d_reg));

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.center      = d_reg;
        cmd.half        = half_reg;
        cmd.smooth      = eligible;
        cmd.out_last    = last_reg && (d_reg == '0);
        cmd.take_point  = accept;
        cmd.diff_en     = (state_reg == S_DIFF);
        cmd.square_en   = (state_reg == S_SQUARE);
        cmd.flag_wr     = (state_reg == S_FLAG) && (k_reg >= SW'(2));
        cmd.sweep_start = (state_reg == S_START);
        cmd.out_load    = (state_reg == S_OUT) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            half_reg  <= '0;
            d_reg     <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (k_reg == '0)
                        begin
                            half_reg <= half_new;
                        end
                        last_reg  <= in_last;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    state_reg <= S_SQUARE;
                end
                S_SQUARE:
                begin
                    state_reg <= S_FLAG;
                end
                S_FLAG:
                begin
                    if (!last_reg)
                    begin
                        if (k_reg >= h_plus1)
                        begin
                            d_reg     <= DW'(h_plus1);
                            state_reg <= S_START;
                        end
                        else
                        begin
                            k_reg     <= k_inc;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        d_reg     <= (k_reg < h_plus1) ? DW'(k_reg) : DW'(h_plus1);
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (status.sweep_idle)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (status.out_free)
                    begin
                        if (!last_reg)
                        begin
                            k_reg     <= k_inc;
                            state_reg <= S_IDLE;
                        end
                        else if (d_reg == '0)
                        begin
                            k_reg     <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            d_reg     <= d_reg - DW'(1);
                            state_reg <= S_START;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/curvature_gated_gaussian_smoother.sv
`default_nettype none

// Channel   Role     Transfer carries
// point     sink     point_x, point_y, last_point
// result    source   out_x, out_y, out_last
// cfg       sink     index, data (register write, always ready)
//
// One point is handled at a time. After a transfer on point the sequencer goes
// through the diff, square and flag states for the corner flag, then makes one
// pass over the window per result. A pass covers 2*h+1 taps for a smoothed point,
// else only the center; the last point also flushes up to h+1 further results.
// All taps share a single multiplier pair. Reset clears the sequencer, the flags,
// the ring pointers, valid bits and configuration registers; the point ring needs
// no clearing. A result waiting on result does not stop the next point transfer.
module curvature_gated_gaussian_smoother #(
    parameter int MAX_WINDOW  = 31,
    parameter int COORD_BITS  = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    cggs_point_if.sink    point,
    cggs_result_if.source result,
    cggs_cfg_if.sink      cfg
);

    logic [cggs_pkg::WIN_W-1:0] window_size_reg;
    logic [cggs_pkg::THR_W-1:0] corner_threshold_reg;

    cggs_pkg::cggs_cmd_t    cmd;
    cggs_pkg::cggs_status_t status;

    // The register file takes a write in every cycle. The user must write only while
    // idle (not enforced); a new window size is latched at the next trajectory start.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg      <= cggs_pkg::WINDOW_RESET;
            corner_threshold_reg <= cggs_pkg::THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cggs_pkg::CFG_WINDOW_SIZE:
                begin
                    window_size_reg <= cfg.data[cggs_pkg::WIN_W-1:0];
                end
                cggs_pkg::CFG_CORNER_THRESHOLD:
                begin
                    corner_threshold_reg <= cfg.data[cggs_pkg::THR_W-1:0];
                end
                default:
                begin
                    window_size_reg <= window_size_reg;
                end
            endcase
        end
    end

    // The sequencer tracks the point count, the latched half-width and which
    // window center is being produced.
    cggs_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (point.valid),
        .in_last     (point.last_point),
        .in_ready    (point.ready),
        .window_size (window_size_reg),
        .cmd         (cmd),
        .status      (status)
    );

    // The datapath holds the ring, the corner flags, the flag arithmetic, the
    // weighted-sum pass and the output register.
    cggs_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .COORD_BITS  (COORD_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_x             (point.point_x),
        .in_y             (point.point_y),
        .corner_threshold (corner_threshold_reg),
        .out_x            (result.out_x),
        .out_y            (result.out_y),
        .out_last         (result.out_last),
        .out_valid        (result.valid),
        .out_ready        (result.ready)
    );

endmodule

`default_nettype wire
